@@ hw/rtl/dds_pkg.sv @@
package dds_pkg;

  // Input value width and the number of BCD digits it can need.
  localparam int VALUE_W    = 27;
  localparam int BCD_DIGITS = 9;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = BCD_DIGITS * DIGIT_W;

  // Display geometry.
  localparam int DISPLAY_SLOTS  = 8;
  localparam int RIGHTMOST_POS  = 7;
  localparam int POS_W          = 3;
  localparam int MASK_W         = 8;
  localparam int NUM_DIGITS_DEF = 8;

  // Finished conversion handed from the converter to the digit emitter.
  typedef struct packed {
    logic             valid;
    logic [BCD_W-1:0] bcd;
  } hand_t;

endpackage

@@ hw/rtl/dds_conv.sv @@
module dds_conv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dds_pkg::VALUE_W-1:0] in_value,
  output dds_pkg::hand_t             hand,
  input  logic                       take
);

  localparam int CNT_W = $clog2(dds_pkg::VALUE_W);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_SHIFT = 3'b010,
    C_DONE  = 3'b100
  } conv_state_t;

  conv_state_t                       state_r, state_nxt;
  logic [dds_pkg::VALUE_W-1:0]       bin_r, bin_nxt;
  logic [dds_pkg::BCD_W-1:0]         bcd_r, bcd_nxt;
  logic [dds_pkg::BCD_W-1:0]         adj;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    logic [dds_pkg::DIGIT_W-1:0] d;
    for (int i = 0; i < dds_pkg::BCD_DIGITS; i++) begin
      d = bcd_r[i*dds_pkg::DIGIT_W +: dds_pkg::DIGIT_W];
      adj[i*dds_pkg::DIGIT_W +: dds_pkg::DIGIT_W] =
        (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  // One input bit enters the BCD register per cycle, most significant first.
  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          bin_nxt   = in_value;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = C_SHIFT;
        end
      end
      C_SHIFT: begin
        bcd_nxt = {adj[dds_pkg::BCD_W-2:0], bin_r[dds_pkg::VALUE_W-1]};
        bin_nxt = {bin_r[dds_pkg::VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(dds_pkg::VALUE_W - 1)) begin
          state_nxt = C_DONE;
        end
      end
      C_DONE: begin
        if (take) begin
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Data path registers need no reset.
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign in_ready   = (state_r == C_IDLE);
  assign hand.valid = (state_r == C_DONE);
  assign hand.bcd   = bcd_r;

endmodule

@@ hw/rtl/dds_emit.sv @@
module dds_emit #(
  parameter int NUM_DIGITS = dds_pkg::NUM_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dds_pkg::hand_t              hand,
  output logic                        take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dds_pkg::POS_W-1:0]   out_position,
  output logic [dds_pkg::MASK_W-1:0]  out_select_mask,
  output logic [dds_pkg::DIGIT_W-1:0] out_digit,
  output logic                        out_last
);

  // Digits shown, clamped to the display.
  localparam int LIM = (NUM_DIGITS > dds_pkg::DISPLAY_SLOTS) ? dds_pkg::DISPLAY_SLOTS :
                       ((NUM_DIGITS < 1) ? 1 : NUM_DIGITS);

  typedef enum logic [1:0] {
    E_IDLE = 2'b01,
    E_RUN  = 2'b10
  } emit_state_t;

  emit_state_t                       state_r, state_nxt;
  logic [dds_pkg::BCD_W-1:0]         dig_r, dig_nxt;
  logic [dds_pkg::POS_W-1:0]         idx_r, idx_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [dds_pkg::POS_W-1:0]         pos_r, pos_nxt;
  logic [dds_pkg::MASK_W-1:0]        mask_r, mask_nxt;
  logic [dds_pkg::DIGIT_W-1:0]       digit_r, digit_nxt;
  logic                              last_r, last_nxt;
  logic                              load_out;
  logic                              last_w;
  logic [dds_pkg::POS_W-1:0]         pos_w;

  // The output register may take a new item when empty or being drained.
  assign load_out = !out_valid_r || out_ready;
  assign take     = (state_r == E_IDLE) && hand.valid;

  // The current digit is the last when nothing higher remains or the limit is hit.
  assign last_w = (dig_r[dds_pkg::BCD_W-1:dds_pkg::DIGIT_W] == '0) ||
                  (idx_r == dds_pkg::POS_W'(LIM - 1));
  assign pos_w  = dds_pkg::POS_W'(dds_pkg::RIGHTMOST_POS) - idx_r;

  // Shift one BCD digit out per emitted item, least significant first.
  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    pos_nxt       = pos_r;
    mask_nxt      = mask_r;
    digit_nxt     = digit_r;
    last_nxt      = last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      E_IDLE: begin
        if (hand.valid) begin
          dig_nxt   = hand.bcd;
          idx_nxt   = '0;
          state_nxt = E_RUN;
        end
      end
      E_RUN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_w;
          mask_nxt      = ~(dds_pkg::MASK_W'(1) << pos_w);
          digit_nxt     = dig_r[dds_pkg::DIGIT_W-1:0];
          last_nxt      = last_w;
          dig_nxt       = dig_r >> dds_pkg::DIGIT_W;
          idx_nxt       = idx_r + 1'b1;
          if (last_w) begin
            state_nxt = E_IDLE;
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Data path registers need no reset.
  always_ff @(posedge clk) begin
    dig_r   <= dig_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    mask_r  <= mask_nxt;
    digit_r <= digit_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_position    = pos_r;
  assign out_select_mask = mask_r;
  assign out_digit       = digit_r;
  assign out_last        = last_r;

endmodule

@@ hw/rtl/decimal_digit_scan_out.sv @@
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_value[26:0]
// out_      output     out_valid / out_ready  out_position, out_select_mask, out_digit, out_last
//
// An item is taken when the converter is free, then shift-and-add-3 builds nine
// BCD digits, one input bit per cycle, and hands them to the emitter once it is idle.
// The emitter then gives one digit per cycle while out_ready is high, and the next
// conversion runs while the previous digits are still being emitted.
// Reset is synchronous and active low; it clears control state only.
// With out_ready low a full output register holds its item and a finished conversion waits.
module decimal_digit_scan_out #(
  parameter int NUM_DIGITS = dds_pkg::NUM_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dds_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dds_pkg::POS_W-1:0]   out_position,
  output logic [dds_pkg::MASK_W-1:0]  out_select_mask,
  output logic [dds_pkg::DIGIT_W-1:0] out_digit,
  output logic                        out_last
);

  dds_pkg::hand_t hand;
  logic           take;

  // Binary to BCD converter.
  dds_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .hand     (hand),
    .take     (take)
  );

  // Digit emitter with output register.
  dds_emit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .hand            (hand),
    .take            (take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_position    (out_position),
    .out_select_mask (out_select_mask),
    .out_digit       (out_digit),
    .out_last        (out_last)
  );

endmodule

@@ hw/rtl/dds_check.sv @@
module dds_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dds_pkg::POS_W-1:0]   out_position,
  input logic [dds_pkg::MASK_W-1:0]  out_select_mask,
  input logic [dds_pkg::DIGIT_W-1:0] out_digit,
  input logic                        out_last
);

  logic [dds_pkg::POS_W-1:0] exp_pos_r;

  // Track the position the next result item must carry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_pos_r <= dds_pkg::POS_W'(dds_pkg::RIGHTMOST_POS);
    end else if (out_valid && out_ready) begin
      exp_pos_r <= out_last ? dds_pkg::POS_W'(dds_pkg::RIGHTMOST_POS)
                            : out_position - 1'b1;
    end
  end

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position) &&
    $stable(out_digit) && $stable(out_last) && $stable(out_select_mask))
    else $error("stalled result item changed");

  // Positions run from the right end leftward, one per item.
  a_pos_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position == exp_pos_r)
    else $error("result position out of sequence");

  // The select byte clears exactly the bit of the position.
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(out_select_mask) == 7 && !out_select_mask[out_position])
    else $error("select mask does not match position");

  // Every emitted digit is decimal.
  a_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit <= 4'd9)
    else $error("digit out of decimal range");

  // The leftmost display position always ends an item.
  a_last_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_position == 3'd0 |-> out_last)
    else $error("item runs past the leftmost position");

endmodule

bind decimal_digit_scan_out dds_check u_dds_check (.*);
